### rtl/core/vlhs_pkg.sv
// package for the varint length hex serializer
// holds action codes, controller state, command and status types, hex lookup
// no dependencies
package vlhs_pkg;

  localparam int LENGTH_BITS_DEF = 32;
  localparam int GROUP_BITS      = 7;

  localparam logic [1:0] ACT_HDR  = 2'd0;
  localparam logic [1:0] ACT_DATA = 2'd1;
  localparam logic [1:0] ACT_END  = 2'd2;

  localparam logic [6:0] CHAR_NL  = 7'h0A;
  localparam logic [6:0] CHAR_0   = 7'h30;
  localparam logic [6:0] CHAR_A   = 7'h41;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_LO,
    ST_NL
  } state_e;

  typedef enum logic [1:0] {
    SEL_HI,
    SEL_LO,
    SEL_NL
  } sel_e;

  typedef struct packed {
    logic load;
    logic next_byte;
    logic emit;
    logic last;
    sel_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_byte;
    logic out_free;
  } dp_stat_t;

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] wide;
    wide = {3'b000, nib};
    if (nib < 4'd10) begin
      return CHAR_0 + wide;
    end
    return CHAR_A + (wide - 7'd10);
  endfunction

endpackage

### rtl/core/vlhs_ctrl.sv
// controller state machine for the varint length hex serializer
// sequences high nibble, low nibble and newline characters; uses vlhs_pkg
module vlhs_ctrl import vlhs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] action_i,
  input  dp_stat_t   stat_i,
  output ctrl_cmd_t  cmd_o
);

  state_e st_q, st_d;
  logic   fin;
  logic   accept;

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.sel       = SEL_HI;
    unique case (st_q)
      ST_IDLE: begin
        cmd_o.emit = 1'b0;
      end
      ST_HI: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_HI;
      end
      ST_LO: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_LO;
        cmd_o.last = stat_i.last_byte;
      end
      ST_NL: begin
        cmd_o.emit = stat_i.out_free;
        cmd_o.sel  = SEL_NL;
        cmd_o.last = 1'b1;
      end
      default: begin
        cmd_o.emit = 1'b0;
      end
    endcase
    fin             = cmd_o.emit && cmd_o.last;
    in_stall_o      = !((st_q == ST_IDLE) || fin);
    accept          = in_valid_i && !in_stall_o;
    cmd_o.load      = accept;
    cmd_o.next_byte = (st_q == ST_LO) && cmd_o.emit && !stat_i.last_byte;
  end

  // next state
  always_comb begin
    st_d = st_q;
    if (accept) begin
      unique case (action_i) inside
        ACT_HDR, ACT_DATA: st_d = ST_HI;
        ACT_END:           st_d = ST_NL;
        default:           st_d = ST_IDLE;
      endcase
    end else if (cmd_o.emit) begin
      unique case (st_q)
        ST_HI:   st_d = ST_LO;
        ST_LO:   st_d = stat_i.last_byte ? ST_IDLE : ST_HI;
        ST_NL:   st_d = ST_IDLE;
        default: st_d = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> ((st_q == ST_IDLE) || (cmd_o.emit && cmd_o.last)))
    else $error("item taken while previous item still in progress");

  a_load_excl_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.load && cmd_o.next_byte))
    else $error("load and next byte in the same cycle");

  a_hi_then_lo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_HI) && cmd_o.emit |=> (st_q == ST_LO))
    else $error("low nibble does not follow high nibble");

  a_more_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.next_byte |=> (st_q == ST_HI) && !$past(cmd_o.last))
    else $error("continuation byte not sequenced");
`endif

endmodule

### rtl/core/vlhs_dp.sv
// datapath for the varint length hex serializer
// length shift register, current byte, output register; uses vlhs_pkg
module vlhs_dp import vlhs_pkg::*; #(
  parameter int LengthBits = LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  input  ctrl_cmd_t   cmd_i,
  output dp_stat_t    stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_out_o,
  output logic        last_o
);

  logic [LengthBits-1:0] len_q, len_d;
  logic [7:0]            byte_q, byte_d;
  logic                  hdr_q, hdr_d;
  logic                  out_valid_q;
  logic [6:0]            char_q;
  logic                  last_q;
  logic [LengthBits-1:0] len_in;
  logic [LengthBits-1:0] len_in_rest;
  logic [LengthBits-1:0] len_rest;
  logic [6:0]            char_d;

  assign len_in      = value_i[LengthBits-1:0];
  assign len_in_rest = len_in >> GROUP_BITS;
  assign len_rest    = len_q >> GROUP_BITS;

  always_comb begin
    len_d  = len_q;
    byte_d = byte_q;
    hdr_d  = hdr_q;
    if (cmd_i.load) begin
      if (action_i == ACT_HDR) begin
        hdr_d  = 1'b1;
        len_d  = len_in_rest;
        byte_d = {len_in_rest != '0, len_in[GROUP_BITS-1:0]};
      end else begin
        hdr_d  = 1'b0;
        byte_d = value_i[7:0];
      end
    end else if (cmd_i.next_byte) begin
      len_d  = len_rest;
      byte_d = {len_rest != '0, len_q[GROUP_BITS-1:0]};
    end
  end

  always_comb begin
    case (cmd_i.sel)
      SEL_HI:  char_d = hex_char(byte_q[7:4]);
      SEL_LO:  char_d = hex_char(byte_q[3:0]);
      default: char_d = CHAR_NL;
    endcase
  end

  always_ff @(posedge clk_i) begin
    len_q  <= len_d;
    byte_q <= byte_d;
    hdr_q  <= hdr_d;
    if (cmd_i.emit) begin
      char_q <= char_d;
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.last_byte = !(hdr_q && byte_q[7]);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;
  assign out_valid_o      = out_valid_q;
  assign char_out_o       = char_q;
  assign last_o           = last_q;

endmodule

### rtl/core/varint_length_hex_serializer.sv
// varint length hex serializer: one character per cycle while the output is not stalled
// an item goes to the state and byte registers, then each character to the output register
// two hex chars per data item, a newline per end item, two per header varint byte (2..10)
// the next item is taken in the cycle the final character of the current one is registered
// reset clears controller state and output valid; payload registers are not reset
module varint_length_hex_serializer import vlhs_pkg::*; #(
  parameter int LengthBits = LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  char_out_o,
  output logic        last_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  vlhs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .action_i   (action_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vlhs_dp #(
    .LengthBits (LengthBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_out_o  (char_out_o),
    .last_o      (last_o)
  );

endmodule
